### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");

// Implication checked on the next edge while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");

`endif

### hw/rtl/kma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kma_pkg;
	// Item commands.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_SLOT  = 2'd1;
	localparam logic [1:0] CMD_RUN   = 2'd2;
	// Unassigned code; the block ignores it.
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_NUM_POINTS  = 2'd0;
	localparam logic [1:0] REG_NUM_MEDOIDS = 2'd1;

	localparam int COST_W = 30;
	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	typedef logic [COST_W-1:0] cost_t;
endpackage
`default_nettype wire

### hw/rtl/kma_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// Input item channel.
interface kma_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [5:0]  row_index;
	logic [5:0]  col_index;
	logic [23:0] distance_value;
	logic [3:0]  slot_select;
	logic [5:0]  point_select;
	modport source (output valid, command, row_index, col_index, distance_value,
		slot_select, point_select, input ready);
	modport sink (input valid, command, row_index, col_index, distance_value,
		slot_select, point_select, output ready);
endinterface

// Result item channel.
interface kma_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  out_slot;
	logic [5:0]  new_medoid;
	logic        moved;
	logic [29:0] total_cost;
	logic        last;
	modport source (output valid, out_slot, new_medoid, moved, total_cost, last,
		input ready);
	modport sink (input valid, out_slot, new_medoid, moved, total_cost, last,
		output ready);
endinterface

// Configuration write channel.
interface kma_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [6:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/kma_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Single-port RAM with registered read.
module kma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### hw/rtl/kmedoids_assign_update.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Role   | Carries
// item_in   | sink   | command, row_index, col_index, distance_value, slot_select, point_select
// result    | source | out_slot, new_medoid, moved, total_cost, last
// cfg       | sink   | index, data (num_points, num_medoids)
//
// A run first assigns every point to its nearest medoid slot, then for each slot scans
// the points and sums, for each member, its distances to all members: every distance
// comes from the one single-port distance RAM. No item is taken during a run.
// Reset clears the medoid slots to zero and the registers to 64 points, 1 slot.
// A stalled result holds the sequencer in its output state.
`include "assert_macros.svh"
module kmedoids_assign_update #(
	parameter int MAX_POINTS  = 64,
	parameter int MAX_MEDOIDS = 16,
	parameter int DIST_WIDTH  = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	kma_in_if.sink   item_in,
	kma_out_if.source result,
	kma_cfg_if.sink  cfg
);
	import kma_pkg::*;

	localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW  = PW + 1;
	localparam int KW  = (MAX_MEDOIDS > 1) ? $clog2(MAX_MEDOIDS) : 1;
	localparam int KCW = KW + 1;
	localparam int DW  = DIST_WIDTH;
	localparam int SW  = DW + PW + 1;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_A_RD   = 11'b00000000010,
		ST_A_CMP  = 11'b00000000100,
		ST_A_CRD  = 11'b00000001000,
		ST_A_CACC = 11'b00000010000,
		ST_U_JRD  = 11'b00000100000,
		ST_U_JCHK = 11'b00001000000,
		ST_U_KRD  = 11'b00010000000,
		ST_U_KACC = 11'b00100000000,
		ST_U_DEC  = 11'b01000000000,
		ST_U_OUT  = 11'b10000000000
	} state_t;

	state_t          state_q;
	logic [6:0]      num_points_q;
	logic [4:0]      num_medoids_q;
	logic [PW-1:0]   med_q [MAX_MEDOIDS];
	logic [CW-1:0]   i_q, j_q, k_q;
	logic [KCW-1:0]  s_q;
	logic [KW-1:0]   best_q;
	logic [DW-1:0]   bd_q;
	cost_t           cost_q;
	logic [SW-1:0]   sum_q, bsum_q;
	logic [PW-1:0]   bestp_q;
	logic            have_q;
	logic            out_valid_q;
	logic [3:0]      out_slot_q;
	logic [5:0]      out_medoid_q;
	logic            out_moved_q;
	cost_t           out_cost_q;
	logic            out_last_q;

	logic [CW-1:0]   np;
	logic [KCW-1:0]  nk;
	logic            in_acc, out_load, run_start;
	logic            wr_ok, slot_ok;
	logic            d_we;
	logic [2*PW-1:0] d_addr;
	logic [DW-1:0]   d_wdata, d_rdata;
	logic            c_we;
	logic [PW-1:0]   c_addr;
	logic [KW-1:0]   c_rdata;
	logic [32:0]     cost_sum;
	logic [PW-1:0]   new_med;

	// Register values clipped to the supported range.
	always_comb begin
		if (32'(num_points_q) > MAX_POINTS) begin
			np = CW'(MAX_POINTS);
		end else begin
			np = CW'(num_points_q);
		end
		if (32'(num_medoids_q) > MAX_MEDOIDS) begin
			nk = KCW'(MAX_MEDOIDS);
		end else begin
			nk = KCW'(num_medoids_q);
		end
	end

	assign item_in.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign in_acc        = item_in.valid && item_in.ready;
	assign run_start     = in_acc && (item_in.command == CMD_RUN) && (nk != '0);
	assign wr_ok = (32'(item_in.row_index) < MAX_POINTS) &&
		(32'(item_in.col_index) < MAX_POINTS);
	assign slot_ok = (32'(item_in.slot_select) < MAX_MEDOIDS) &&
		(32'(item_in.point_select) < MAX_POINTS);
	assign out_load = (state_q == ST_U_OUT) && (!out_valid_q || result.ready);

	// Distance RAM port selection.
	always_comb begin
		d_we    = in_acc && (item_in.command == CMD_WRITE) && wr_ok;
		d_wdata = DW'(item_in.distance_value);
		case (state_q)
			ST_A_RD:  d_addr = {i_q[PW-1:0], med_q[s_q[KW-1:0]]};
			ST_A_CRD: d_addr = {med_q[best_q], i_q[PW-1:0]};
			ST_U_KRD: d_addr = {j_q[PW-1:0], k_q[PW-1:0]};
			default:  d_addr = {PW'(item_in.row_index), PW'(item_in.col_index)};
		endcase
	end

	// Cluster RAM port selection.
	always_comb begin
		c_we = (state_q == ST_A_CACC);
		case (state_q)
			ST_U_JRD: c_addr = j_q[PW-1:0];
			ST_U_KRD: c_addr = k_q[PW-1:0];
			default:  c_addr = i_q[PW-1:0];
		endcase
	end

	kma_ram #(.WIDTH(DW), .DEPTH(1 << (2 * PW))) u_dist_ram (
		.clk   (clk),
		.we    (d_we),
		.addr  (d_addr),
		.wdata (d_wdata),
		.rdata (d_rdata)
	);

	kma_ram #(.WIDTH(KW), .DEPTH(1 << PW)) u_cluster_ram (
		.clk   (clk),
		.we    (c_we),
		.addr  (c_addr),
		.wdata (best_q),
		.rdata (c_rdata)
	);

	assign cost_sum = 33'(cost_q) + 33'(d_rdata);
	assign new_med  = have_q ? bestp_q : med_q[s_q[KW-1:0]];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q  <= 7'd64;
			num_medoids_q <= 5'd1;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_NUM_POINTS) begin
				num_points_q <= cfg.data;
			end else if (cfg.index == REG_NUM_MEDOIDS) begin
				num_medoids_q <= cfg.data[4:0];
			end
		end
	end

	// Medoid slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MAX_MEDOIDS; m++) begin
				med_q[m] <= '0;
			end
		end else if (in_acc && (item_in.command == CMD_SLOT) && slot_ok) begin
			med_q[KW'(item_in.slot_select)] <= PW'(item_in.point_select);
		end else if (out_load) begin
			med_q[s_q[KW-1:0]] <= new_med;
		end
	end

	// Sequencer for assignment, cost and medoid update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			s_q     <= '0;
			have_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					i_q    <= '0;
					j_q    <= '0;
					s_q    <= '0;
					have_q <= 1'b0;
					if (run_start) begin
						state_q <= (np == '0) ? ST_U_JRD : ST_A_RD;
					end
				end
				ST_A_RD: state_q <= ST_A_CMP;
				ST_A_CMP: begin
					if (s_q + 1'b1 == nk) begin
						state_q <= ST_A_CRD;
					end else begin
						s_q     <= s_q + 1'b1;
						state_q <= ST_A_RD;
					end
				end
				ST_A_CRD: state_q <= ST_A_CACC;
				ST_A_CACC: begin
					s_q <= '0;
					if (i_q + 1'b1 == np) begin
						state_q <= ST_U_JRD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_A_RD;
					end
				end
				ST_U_JRD: state_q <= (j_q == np) ? ST_U_OUT : ST_U_JCHK;
				ST_U_JCHK: begin
					k_q <= '0;
					if (c_rdata == s_q[KW-1:0]) begin
						state_q <= ST_U_KRD;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_U_JRD;
					end
				end
				ST_U_KRD: state_q <= ST_U_KACC;
				ST_U_KACC: begin
					k_q     <= k_q + 1'b1;
					state_q <= (k_q + 1'b1 == np) ? ST_U_DEC : ST_U_KRD;
				end
				ST_U_DEC: begin
					have_q  <= 1'b1;
					j_q     <= j_q + 1'b1;
					state_q <= ST_U_JRD;
				end
				ST_U_OUT: begin
					if (out_load) begin
						j_q    <= '0;
						have_q <= 1'b0;
						if (s_q + 1'b1 == nk) begin
							state_q <= ST_IDLE;
						end else begin
							s_q     <= s_q + 1'b1;
							state_q <= ST_U_JRD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: nearest slot, cost and in-cluster sums.
	always_ff @(posedge clk) begin
		if (run_start) begin
			cost_q <= '0;
		end
		if (state_q == ST_A_CMP) begin
			if (s_q == '0 || d_rdata < bd_q) begin
				bd_q   <= d_rdata;
				best_q <= s_q[KW-1:0];
			end
		end
		if (state_q == ST_A_CACC) begin
			cost_q <= (cost_sum > 33'(COST_MAX)) ? COST_MAX : cost_sum[COST_W-1:0];
		end
		if (state_q == ST_U_JCHK) begin
			sum_q <= '0;
		end
		if (state_q == ST_U_KACC && c_rdata == s_q[KW-1:0]) begin
			sum_q <= sum_q + SW'(d_rdata);
		end
		if (state_q == ST_U_DEC && (!have_q || !(bsum_q < sum_q))) begin
			bsum_q  <= sum_q;
			bestp_q <= j_q[PW-1:0];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_slot_q   <= 4'(s_q);
			out_medoid_q <= 6'(new_med);
			out_moved_q  <= have_q && (bestp_q != med_q[s_q[KW-1:0]]);
			out_cost_q   <= cost_q;
			out_last_q   <= (s_q + 1'b1 == nk);
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_slot   = out_slot_q;
	assign result.new_medoid = out_medoid_q;
	assign result.moved      = out_moved_q;
	assign result.total_cost = out_cost_q;
	assign result.last       = out_last_q;

	`ASSERT_NEXT(a_run_leaves_idle, clk, arst_n, run_start, state_q != ST_IDLE)
	`ASSERT_NEXT(a_last_ends_run, clk, arst_n, out_load && (s_q + 1'b1 == nk),
		state_q == ST_IDLE)
	`ASSERT_CLK(a_cluster_wr_in_range, clk, arst_n, c_we |-> (i_q < np))
endmodule
`default_nettype wire
